FILE: src/assert_macros.svh
// Assertion helpers used by the heap RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/ibh_pkg.sv
package ibh_pkg;
  localparam int HEAP_DEPTH_DEF = 64;
  localparam int TAG_COUNT_DEF  = 64;
  localparam int KEY_BITS_DEF   = 32;

  localparam int CMD_W    = 3;
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 6;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT    = 3'd0,
    CMD_POP    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_REKEY  = 3'd3,
    CMD_UPSERT = 3'd4,
    CMD_PEEK   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_QUEUED   = 2'd3
  } status_t;
endpackage

FILE: src/ibh_if.sv
interface ibh_req_if;
  import ibh_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [KEY_W-1:0]   key;
  logic [TAG_W-1:0]   tag;
  logic [POS_W-1:0]   position;
  modport source (output valid, cmd, key, tag, position, input ready);
  modport sink   (input valid, cmd, key, tag, position, output ready);
endinterface

interface ibh_rsp_if;
  import ibh_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    out_tag;
  logic [KEY_W-1:0]    out_key;
  logic [OCC_W-1:0]    occupancy;
  modport source (output valid, status, out_tag, out_key, occupancy, input ready);
  modport sink   (input valid, status, out_tag, out_key, occupancy, output ready);
endinterface

interface ibh_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: src/ibh_cmp.sv
module ibh_cmp #(
  parameter int KW = 32
) (
  input  logic          descending,
  input  logic [KW-1:0] a,
  input  logic [KW-1:0] b,
  output logic          a_first
);
  // Strict ordering: equal keys never move past each other.
  assign a_first = descending ? (a > b) : (a < b);
endmodule

FILE: src/ibh_heap_ram.sv
module ibh_heap_ram #(
  parameter int DEPTH = 64,
  parameter int KW    = 32,
  parameter int TW    = 6
) (
  input  logic                     clk,
  input  logic                     ra_en,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [KW-1:0]            ra_key,
  output logic [TW-1:0]            ra_tag,
  input  logic                     rb_en,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [KW-1:0]            rb_key,
  output logic [TW-1:0]            rb_tag,
  input  logic                     w_en,
  input  logic [$clog2(DEPTH)-1:0] w_addr,
  input  logic [KW-1:0]            w_key,
  input  logic [TW-1:0]            w_tag
);
  logic [KW-1:0] keys [DEPTH];
  logic [TW-1:0] tags [DEPTH];

  always_ff @(posedge clk) begin
    if (w_en) begin
      keys[w_addr] <= w_key;
      tags[w_addr] <= w_tag;
    end
    if (ra_en) begin
      ra_key <= keys[ra_addr];
      ra_tag <= tags[ra_addr];
    end
    if (rb_en) begin
      rb_key <= keys[rb_addr];
      rb_tag <= tags[rb_addr];
    end
  end
endmodule

FILE: src/ibh_slot_ram.sv
module ibh_slot_ram #(
  parameter int DEPTH = 64,
  parameter int DW    = 7
) (
  input  logic                     clk,
  input  logic                     r_en,
  input  logic [$clog2(DEPTH)-1:0] r_addr,
  output logic [DW-1:0]            r_data,
  input  logic                     w_en,
  input  logic [$clog2(DEPTH)-1:0] w_addr,
  input  logic [DW-1:0]            w_data
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (w_en) begin
      mem[w_addr] <= w_data;
    end
    if (r_en) begin
      r_data <= mem[r_addr];
    end
  end
endmodule

FILE: src/indexed_binary_min_heap.sv
// Channel   Direction  Carries
// rq        in         cmd, key, tag, position
// rsp       out        status, out_tag, out_key, occupancy
// cfg       in         order_descending (data)
//
// With no change of shape, an accepted command passes S_RD, S_DEC and S_DONE before rsp.valid.
// A put sifts up from the new last slot and ends in S_FIN. A sift-down takes S_DISS, S_DCMPL
// and S_DCMPR per level, a sift-up S_UISS and S_UCMP per level, and a pop or remove that
// refills a hole first reads the last entry in S_LAST and S_LASTD.
// rq.ready stays low while a result waits, and returns the cycle after rsp is taken.
// After reset the tag position memory is swept clear with rq.ready low; cfg writes
// are taken at any time.
module indexed_binary_min_heap #(
  parameter int HEAP_DEPTH = ibh_pkg::HEAP_DEPTH_DEF,
  parameter int TAG_COUNT  = ibh_pkg::TAG_COUNT_DEF,
  parameter int KEY_BITS   = ibh_pkg::KEY_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  ibh_req_if.sink rq,
  ibh_rsp_if.source rsp,
  ibh_cfg_if.sink cfg
);
  import ibh_pkg::*;
`include "assert_macros.svh"

  localparam int PI  = $clog2(HEAP_DEPTH);
  localparam int CW  = $clog2(HEAP_DEPTH + 1);
  localparam int CHW = PI + 2;
  localparam int TI  = $clog2(TAG_COUNT);
  localparam int SK  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam logic [CW-1:0] NOT_QUEUED = CW'(HEAP_DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_DEC, S_LAST, S_LASTD, S_DISS, S_DCMPL, S_DCMPR,
    S_UISS, S_UCMP, S_FIN, S_DONE
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          order;
  logic [TI-1:0] clr;
  logic [CMD_W-1:0] cmd_q;
  logic [SK-1:0]    key_q;
  logic [TAG_W-1:0] tag_q;
  logic [POS_W-1:0] pos_q;
  logic [SK-1:0]    x_key;
  logic [TAG_W-1:0] x_tag;
  logic [PI-1:0]    hole;
  logic             moved;
  logic             best_sel;
  logic [SK-1:0]    best_key;
  logic [TAG_W-1:0] best_tag;
  logic [STATUS_W-1:0] res_status;
  logic [TAG_W-1:0]    res_tag;
  logic [SK-1:0]       res_key;

  logic             ra_en, rb_en, hw_en;
  logic [PI-1:0]    ra_addr, rb_addr, hw_addr;
  logic [SK-1:0]    ra_key, rb_key, hw_key;
  logic [TAG_W-1:0] ra_tag, rb_tag, hw_tag;
  logic             sr_en, sw_en;
  logic [TI-1:0]    sr_addr, sw_addr;
  logic [CW-1:0]    slot_rd, sw_data;

  logic [SK-1:0]  cmp_a, cmp_b;
  logic           first;
  logic [CHW-1:0] left, right;
  logic [PI-1:0]  parent;
  logic           tag_ok, queued, full, do_insert, do_rekey;
  logic           right_move, down_move;
  logic [SK-1:0]  child_key;
  logic [TAG_W-1:0] child_tag;
  logic [PI-1:0]  child_pos;

  ibh_heap_ram #(.DEPTH(HEAP_DEPTH), .KW(SK), .TW(TAG_W)) u_heap (
    .clk(clk),
    .ra_en(ra_en), .ra_addr(ra_addr), .ra_key(ra_key), .ra_tag(ra_tag),
    .rb_en(rb_en), .rb_addr(rb_addr), .rb_key(rb_key), .rb_tag(rb_tag),
    .w_en(hw_en), .w_addr(hw_addr), .w_key(hw_key), .w_tag(hw_tag)
  );

  ibh_slot_ram #(.DEPTH(TAG_COUNT), .DW(CW)) u_slot (
    .clk(clk),
    .r_en(sr_en), .r_addr(sr_addr), .r_data(slot_rd),
    .w_en(sw_en), .w_addr(sw_addr), .w_data(sw_data)
  );

  ibh_cmp #(.KW(SK)) u_cmp (
    .descending(order), .a(cmp_a), .b(cmp_b), .a_first(first)
  );

  assign left   = {1'b0, hole, 1'b1};
  assign right  = left + 1'b1;
  assign parent = (hole - 1'b1) >> 1;
  assign tag_ok = tag_q < TAG_COUNT;
  assign queued = tag_ok && (slot_rd < cnt);
  assign full   = cnt >= NOT_QUEUED;
  assign do_insert = tag_ok && !queued &&
                     ((cmd_q == CMD_PUT) || (cmd_q == CMD_UPSERT));
  assign do_rekey  = queued && ((cmd_q == CMD_REKEY) || (cmd_q == CMD_UPSERT));

  assign right_move = (right < CHW'(cnt)) && first;
  assign down_move  = right_move || best_sel;
  assign child_key  = right_move ? rb_key : best_key;
  assign child_tag  = right_move ? rb_tag : best_tag;
  assign child_pos  = right_move ? right[PI-1:0] : left[PI-1:0];

  // The result registers and the count must hold while a result waits.
  assign rq.ready  = (state == S_IDLE) && !rsp.valid;
  assign cfg.ready = 1'b1;
  assign rsp.status    = res_status;
  assign rsp.out_tag   = res_tag;
  assign rsp.out_key   = KEY_W'(res_key);
  assign rsp.occupancy = OCC_W'(cnt);

  always_comb begin
    case (state)
      S_DCMPL: begin
        cmp_a = ra_key;
        cmp_b = x_key;
      end
      S_DCMPR: begin
        cmp_a = rb_key;
        cmp_b = best_key;
      end
      default: begin
        cmp_a = x_key;
        cmp_b = ra_key;
      end
    endcase
  end

  always_comb begin
    ra_en = 1'b0;
    ra_addr = '0;
    rb_en = 1'b0;
    rb_addr = '0;
    hw_en = 1'b0;
    hw_addr = hole;
    hw_key = x_key;
    hw_tag = x_tag;
    sr_en = 1'b0;
    sr_addr = TI'(tag_q);
    sw_en = 1'b0;
    sw_addr = TI'(x_tag);
    sw_data = CW'(hole);
    case (state)
      S_CLEAR: begin
        sw_en = 1'b1;
        sw_addr = clr;
        sw_data = NOT_QUEUED;
      end
      S_RD: begin
        sr_en = 1'b1;
        ra_en = 1'b1;
        ra_addr = (cmd_q == CMD_PEEK) ? PI'(pos_q) : '0;
      end
      S_DEC: begin
        if (cmd_q == CMD_POP && cnt != '0) begin
          sw_en = 1'b1;
          sw_addr = TI'(ra_tag);
          sw_data = NOT_QUEUED;
        end else if (cmd_q == CMD_REMOVE && queued) begin
          sw_en = 1'b1;
          sw_addr = TI'(tag_q);
          sw_data = NOT_QUEUED;
        end
      end
      S_LAST: begin
        ra_en = 1'b1;
        ra_addr = PI'(cnt);
      end
      S_DISS: begin
        if (left < CHW'(cnt)) begin
          ra_en = 1'b1;
          ra_addr = left[PI-1:0];
          rb_en = 1'b1;
          rb_addr = right[PI-1:0];
        end
      end
      S_DCMPR: begin
        if (down_move) begin
          hw_en = 1'b1;
          hw_key = child_key;
          hw_tag = child_tag;
          sw_en = 1'b1;
          sw_addr = TI'(child_tag);
        end
      end
      S_UISS: begin
        if (hole != '0) begin
          ra_en = 1'b1;
          ra_addr = parent;
        end
      end
      S_UCMP: begin
        if (first) begin
          hw_en = 1'b1;
          hw_key = ra_key;
          hw_tag = ra_tag;
          sw_en = 1'b1;
          sw_addr = TI'(ra_tag);
        end
      end
      S_FIN: begin
        hw_en = 1'b1;
        sw_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      order <= 1'b0;
      clr <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        order <= cfg.data;
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == TI'(TAG_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (rq.valid && rq.ready) begin
            cmd_q <= rq.cmd;
            key_q <= rq.key[SK-1:0];
            tag_q <= rq.tag;
            pos_q <= rq.position;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_DEC;
        end
        S_DEC: begin
          res_status <= ST_NOTFOUND;
          res_tag <= '0;
          res_key <= '0;
          moved <= 1'b0;
          x_key <= key_q;
          x_tag <= tag_q;
          state <= S_DONE;
          if (do_insert) begin
            if (full) begin
              res_status <= ST_FULL;
            end else begin
              res_status <= ST_OK;
              hole <= PI'(cnt);
              cnt <= cnt + 1'b1;
              state <= S_UISS;
            end
          end else if (do_rekey) begin
            res_status <= ST_OK;
            hole <= PI'(slot_rd);
            state <= S_DISS;
          end else begin
            case (cmd_q)
              CMD_PUT: begin
                if (queued) begin
                  res_status <= ST_QUEUED;
                end
              end
              CMD_POP: begin
                if (cnt != '0) begin
                  res_status <= ST_OK;
                  res_tag <= ra_tag;
                  res_key <= ra_key;
                  cnt <= cnt - 1'b1;
                  hole <= '0;
                  if (cnt != CW'(1)) begin
                    state <= S_LAST;
                  end
                end
              end
              CMD_REMOVE: begin
                if (queued) begin
                  res_status <= ST_OK;
                  cnt <= cnt - 1'b1;
                  hole <= PI'(slot_rd);
                  if (slot_rd != cnt - 1'b1) begin
                    state <= S_LAST;
                  end
                end
              end
              CMD_PEEK: begin
                if (pos_q < cnt) begin
                  res_status <= ST_OK;
                  res_tag <= ra_tag;
                  res_key <= ra_key;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_LAST: begin
          state <= S_LASTD;
        end
        S_LASTD: begin
          // The last entry refills the hole and sifts from there.
          x_key <= ra_key;
          x_tag <= ra_tag;
          state <= S_DISS;
        end
        S_DISS: begin
          if (left < CHW'(cnt)) begin
            state <= S_DCMPL;
          end else begin
            state <= moved ? S_FIN : S_UISS;
          end
        end
        S_DCMPL: begin
          best_sel <= first;
          best_key <= first ? ra_key : x_key;
          best_tag <= ra_tag;
          state <= S_DCMPR;
        end
        S_DCMPR: begin
          if (down_move) begin
            hole <= child_pos;
            moved <= 1'b1;
            state <= S_DISS;
          end else begin
            // An entry that went down cannot also go up.
            state <= moved ? S_FIN : S_UISS;
          end
        end
        S_UISS: begin
          state <= (hole == '0) ? S_FIN : S_UCMP;
        end
        S_UCMP: begin
          if (first) begin
            hole <= parent;
            state <= S_UISS;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= NOT_QUEUED)
  `ASSERT_IMPL(a_fin_in_heap, clk, rst, state == S_FIN, CW'(hole) < cnt)
  `ASSERT_IMPL(a_left_in_heap, clk, rst, state == S_DCMPL, left < CHW'(cnt))
  `ASSERT_NEXT(a_rsp_from_done, clk, rst, !rsp.valid && state != S_DONE, !rsp.valid)
endmodule

FILE: verif/heap_tb_if.sv
`timescale 1ns / 1ps
// Interfaces are provided by the RTL (ibh_req_if, ibh_rsp_if, ibh_cfg_if).
// This file holds the transaction types used by the testbench.
package heap_tb_pkg;
  import ibh_pkg::*;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [POS_W-1:0] position;
  } heap_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    out_tag;
    logic [KEY_W-1:0]    out_key;
    logic [OCC_W-1:0]    occupancy;
  } heap_rsp_t;
endpackage

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ibh_pkg::*;
  import heap_tb_pkg::*;

  localparam int DEPTH = 64;
  localparam int TAGS = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_RANDOM = 1850;
  localparam logic [2:0] CMD_BAD6 = 3'd6;
  localparam logic [2:0] CMD_BAD7 = 3'd7;

  logic clk;
  logic rst;

  ibh_req_if rq ();
  ibh_rsp_if rsp ();
  ibh_cfg_if cfg ();

  indexed_binary_min_heap u_top (
    .clk(clk),
    .rst(rst),
    .rq(rq.sink),
    .rsp(rsp.source),
    .cfg(cfg.sink)
  );

  // Predictor state.
  logic [KEY_W-1:0] mdl_keys[DEPTH];
  logic [TAG_W-1:0] mdl_tags[DEPTH];
  int               mdl_slot[TAGS];
  int               mdl_count;
  logic             mdl_desc;

  heap_cmd_t cmd_q[$];
  heap_rsp_t expected_q[$];
  int  errors;
  int  accepted_cmds;
  int  stall_cycles;
  bit  quiet_mode;

  function automatic bit goes_first(int a, int b);
    if (mdl_desc) return mdl_keys[a] > mdl_keys[b];
    return mdl_keys[a] < mdl_keys[b];
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    k = mdl_keys[a];
    t = mdl_tags[a];
    mdl_keys[a] = mdl_keys[b];
    mdl_tags[a] = mdl_tags[b];
    mdl_keys[b] = k;
    mdl_tags[b] = t;
    mdl_slot[mdl_tags[a]] = a;
    mdl_slot[mdl_tags[b]] = b;
  endfunction

  function automatic int climb(int p);
    int parent;
    while (p > 0) begin
      parent = (p - 1) / 2;
      if (!goes_first(p, parent)) break;
      swap_entries(p, parent);
      p = parent;
    end
    return p;
  endfunction

  function automatic int descend(int p);
    int left, right, best;
    forever begin
      left = 2 * p + 1;
      right = left + 1;
      best = p;
      if (left >= mdl_count) break;
      if (goes_first(left, best)) best = left;
      if (right < mdl_count && goes_first(right, best)) best = right;
      if (best == p) break;
      swap_entries(p, best);
      p = best;
    end
    return p;
  endfunction

  function automatic void drop_at(int p);
    int last;
    mdl_slot[mdl_tags[p]] = DEPTH;
    mdl_count--;
    last = mdl_count;
    if (p != last) begin
      mdl_keys[p] = mdl_keys[last];
      mdl_tags[p] = mdl_tags[last];
      mdl_slot[mdl_tags[p]] = p;
      void'(climb(descend(p)));
    end
  endfunction

  function automatic logic [STATUS_W-1:0] add_entry(logic [TAG_W-1:0] tag,
                                                    logic [KEY_W-1:0] key);
    int p;
    if (mdl_count >= DEPTH) return ST_FULL;
    p = mdl_count++;
    mdl_keys[p] = key;
    mdl_tags[p] = tag;
    mdl_slot[tag] = p;
    void'(climb(p));
    return ST_OK;
  endfunction

  function automatic heap_rsp_t predict_heap(heap_cmd_t c);
    heap_rsp_t r;
    bit queued;
    int p;
    queued = mdl_slot[c.tag] < mdl_count;
    r = '0;
    r.status = ST_NOTFOUND;
    case (c.cmd)
      CMD_PUT: begin
        if (queued) r.status = ST_QUEUED;
        else r.status = add_entry(c.tag, c.key);
      end
      CMD_POP: begin
        if (mdl_count > 0) begin
          r.out_tag = mdl_tags[0];
          r.out_key = mdl_keys[0];
          drop_at(0);
          r.status = ST_OK;
        end
      end
      CMD_REMOVE: begin
        if (queued) begin
          drop_at(mdl_slot[c.tag]);
          r.status = ST_OK;
        end
      end
      CMD_REKEY, CMD_UPSERT: begin
        if (queued) begin
          p = mdl_slot[c.tag];
          mdl_keys[p] = c.key;
          void'(climb(descend(p)));
          r.status = ST_OK;
        end else if (c.cmd == CMD_UPSERT) begin
          r.status = add_entry(c.tag, c.key);
        end
      end
      CMD_PEEK: begin
        if (c.position < mdl_count) begin
          r.out_tag = mdl_tags[c.position];
          r.out_key = mdl_keys[c.position];
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.occupancy = mdl_count[OCC_W-1:0];
    return r;
  endfunction

  function automatic heap_cmd_t make_cmd(logic [2:0] op, logic [31:0] key,
                                         logic [5:0] tag, logic [5:0] pos);
    heap_cmd_t c;
    c.cmd = op;
    c.key = key;
    c.tag = tag;
    c.position = pos;
    return c;
  endfunction

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      rq.valid <= 1'b0;
    end else if (!rq.valid || rq.ready) begin
      if (cmd_q.size() > 0 && (quiet_mode || $urandom_range(0, 99) >= 10)) begin
        {rq.cmd, rq.key, rq.tag, rq.position} <= cmd_q.pop_front();
        rq.valid <= 1'b1;
      end else begin
        rq.valid <= 1'b0;
      end
    end
  end

  // Predict at acceptance so the model tracks the block's command order.
  always @(posedge clk) begin
    if (!rst && rq.valid && rq.ready) begin
      expected_q.push_back(predict_heap(make_cmd(rq.cmd, rq.key, rq.tag, rq.position)));
      accepted_cmds++;
    end
  end

  // Response monitor and backpressure.
  always @(posedge clk) begin
    heap_rsp_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= quiet_mode || $urandom_range(0, 99) >= 10;
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected response status=%0d", rsp.status);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.out_tag !== want.out_tag) begin
            $error("out_tag expected %0d actual %0d", want.out_tag, rsp.out_tag);
            errors++;
          end
          if (rsp.out_key !== want.out_key) begin
            $error("out_key expected %0h actual %0h", want.out_key, rsp.out_key);
            errors++;
          end
          if (rsp.occupancy !== want.occupancy) begin
            $error("occupancy expected %0d actual %0d", want.occupancy, rsp.occupancy);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst || (rq.valid && rq.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("indexed_binary_min_heap test failed");
        $finish;
      end
    end
  end

  task automatic write_order(logic value);
    @(posedge clk);
    cfg.data <= value;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    mdl_desc = value;
  endtask

  task automatic wait_drained();
    wait (cmd_q.size() == 0);
    while (expected_q.size() > 0 || (rq.valid && !rq.ready) || rq.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random phase: a small tag_span keeps more commands hitting queued entries.
  task automatic random_phase(int n, int tag_span);
    logic [2:0] op;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) op = CMD_PUT;
      else if (pick < 45) op = CMD_POP;
      else if (pick < 55) op = CMD_REMOVE;
      else if (pick < 67) op = CMD_REKEY;
      else if (pick < 80) op = CMD_UPSERT;
      else if (pick < 97) op = CMD_PEEK;
      else op = pick[0] ? CMD_BAD6 : CMD_BAD7;
      cmd_q.push_back(make_cmd(op, rand_key(), 6'($urandom_range(0, tag_span - 1)),
                               6'($urandom_range(0, 63))));
    end
  endtask

  initial begin
    errors = 0;
    accepted_cmds = 0;
    quiet_mode = 1'b0;
    mdl_desc = 1'b0;
    mdl_count = 0;
    for (int i = 0; i < TAGS; i++) mdl_slot[i] = DEPTH;
    rq.valid = 1'b0;
    rq.cmd = '0;
    rq.key = '0;
    rq.tag = '0;
    rq.position = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = 1'b0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cases, extremes, duplicate, every command, bad codes.
    cmd_q.push_back(make_cmd(CMD_POP, 0, 0, 0));
    cmd_q.push_back(make_cmd(CMD_PEEK, 0, 0, 0));
    cmd_q.push_back(make_cmd(CMD_REMOVE, 0, 5, 0));
    cmd_q.push_back(make_cmd(CMD_REKEY, 1, 5, 0));
    cmd_q.push_back(make_cmd(CMD_PUT, 32'hFFFF_FFFF, 63, 0));
    cmd_q.push_back(make_cmd(CMD_PUT, 32'h0, 0, 0));
    cmd_q.push_back(make_cmd(CMD_PUT, 32'h5, 0, 0));
    cmd_q.push_back(make_cmd(CMD_UPSERT, 32'h7, 21, 0));
    cmd_q.push_back(make_cmd(CMD_UPSERT, 32'h8000_0000, 21, 0));
    cmd_q.push_back(make_cmd(CMD_PEEK, 0, 0, 63));
    cmd_q.push_back(make_cmd(CMD_PEEK, 0, 0, 2));
    cmd_q.push_back(make_cmd(CMD_REKEY, 32'h1, 63, 0));
    cmd_q.push_back(make_cmd(CMD_BAD6, 32'hFFFF_FFFF, 63, 63));
    cmd_q.push_back(make_cmd(CMD_BAD7, 0, 0, 0));
    cmd_q.push_back(make_cmd(CMD_REMOVE, 0, 0, 0));
    cmd_q.push_back(make_cmd(CMD_POP, 0, 0, 0));
    cmd_q.push_back(make_cmd(CMD_POP, 0, 0, 0));
    cmd_q.push_back(make_cmd(CMD_PEEK, 0, 0, 42));
    wait_drained();

    // Fill the heap completely, then put a tag that is already queued.
    for (int t = 0; t < 64; t++) cmd_q.push_back(make_cmd(CMD_PUT, rand_key(), 6'(t), 0));
    cmd_q.push_back(make_cmd(CMD_PUT, 1, 7, 0));
    cmd_q.push_back(make_cmd(CMD_PEEK, 0, 0, 63));
    for (int t = 0; t < 64; t++) cmd_q.push_back(make_cmd(CMD_REMOVE, 0, 6'(t), 0));
    wait_drained();

    write_order(1'b1);
    random_phase(500, 64);
    random_phase(150, 64);
    // The last stretch of this phase runs with no idling on either side.
    wait (cmd_q.size() <= 150);
    quiet_mode = 1'b1;
    wait_drained();
    quiet_mode = 1'b0;
    write_order(1'b0);
    random_phase(600, 64);
    wait_drained();
    write_order(1'b1);
    // Upserts over the whole tag range mix inserts with rekeys, then a phase on 16 tags.
    for (int i = 0; i < 100; i++)
      cmd_q.push_back(make_cmd(CMD_UPSERT, rand_key(), 6'($urandom_range(0, 63)), 0));
    random_phase(350, 16);
    wait_drained();

    if (errors == 0) begin
      $display("indexed_binary_min_heap test passed");
    end else begin
      $display("indexed_binary_min_heap test failed");
    end
    $finish;
  end
endmodule

FILE: indexed_binary_min_heap.f
+incdir+src
src/ibh_pkg.sv
src/ibh_if.sv
src/ibh_cmp.sv
src/ibh_heap_ram.sv
src/ibh_slot_ram.sv
src/indexed_binary_min_heap.sv
verif/heap_tb_if.sv
verif/testbench.sv
